FILE: sv/hsfr_pkg.sv
// Package for the header/sum frame receiver.
// Holds the controller state type and the controller/datapath command and status structs.
`timescale 1ns / 1ps

package hsfr_pkg;

  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_HEADER = 0;    // index of frame_header in the register map
  localparam logic [7:0]  HEADER_RST = 8'hDD;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_CAPTURE,
    ST_READ,
    ST_LOAD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;     // store input byte, advance count and sum
    logic clr;       // end of capture: clear count, sum, read pointer
    logic rd_issue;  // read store at read pointer
    logic out_load;  // load output register from read data
    logic rd_next;   // advance read pointer
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic header_match;
    logic count_last;
    logic sum_match;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

FILE: sv/hsfr_dp.sv
// Datapath of the frame receiver: frame store, capture count, running sum,
// replay pointer and output register. Depends on hsfr_pkg.
`timescale 1ns / 1ps

module hsfr_dp #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  hsfr_pkg::cmd_t   cmd,
  output hsfr_pkg::status_t sts,
  input  logic [7:0]       header,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [3:0]       out_index,
  output logic             out_last
);

  localparam int unsigned AW = $clog2(FRAME_LEN);
  localparam logic [AW-1:0] LAST_POS = AW'(FRAME_LEN - 1);

  logic [7:0]    store [FRAME_LEN];
  logic [AW-1:0] count;
  logic [AW-1:0] rd_idx;
  logic [7:0]    sum;
  logic [7:0]    rd_data;

  assign sts.header_match = (rx_byte == header);
  assign sts.count_last   = (count == LAST_POS);
  assign sts.sum_match    = (sum == rx_byte);
  assign sts.rd_last      = (rd_idx == LAST_POS);
  assign sts.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[count] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sum    <= '0;
      rd_idx <= '0;
    end else begin
      if (cmd.clr) begin
        count  <= '0;
        sum    <= '0;
        rd_idx <= '0;
      end else begin
        if (cmd.wr_en) begin
          count <= count + 1'b1;
          sum   <= sum + rx_byte;  // checksum byte never gets here
        end
        if (cmd.rd_next) begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte  <= rd_data;
      out_index <= 4'(rd_idx);
      out_last  <= (rd_idx == LAST_POS);
    end
  end

endmodule

FILE: sv/hsfr_ctrl.sv
// Controller of the frame receiver: hunt, capture and replay sequencing.
// Depends on hsfr_pkg.
`timescale 1ns / 1ps

module hsfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsfr_pkg::status_t sts,
  output hsfr_pkg::cmd_t    cmd
);

  hsfr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsfr_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      hsfr_pkg::ST_HUNT: begin
        in_ready = 1'b1;
        if (in_valid && sts.header_match) begin
          cmd.wr_en  = 1'b1;
          state_next = hsfr_pkg::ST_CAPTURE;
        end
      end
      hsfr_pkg::ST_CAPTURE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (sts.count_last) begin
            cmd.clr    = 1'b1;
            state_next = sts.sum_match ? hsfr_pkg::ST_READ : hsfr_pkg::ST_HUNT;
          end
        end
      end
      hsfr_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = hsfr_pkg::ST_LOAD;
      end
      hsfr_pkg::ST_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.rd_last) begin
            state_next = hsfr_pkg::ST_HUNT;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = hsfr_pkg::ST_READ;
          end
        end
      end
      default: state_next = hsfr_pkg::ST_HUNT;
    endcase
  end

endmodule

FILE: sv/header_sum_frame_receiver.sv
// Input: a byte is taken every cycle while hunting or capturing. After the byte that
//   completes a good frame, the store is read (ST_READ), then the output register is
//   loaded (ST_LOAD, once free) for each result; no input is taken until replay ends.
//   Bad frames cost nothing.
// Reset: synchronous, active high; hunting, count and sum cleared, frame_header = 0xDD.
//   The frame store is not cleared (every entry is written before it is read).
`timescale 1ns / 1ps

module header_sum_frame_receiver #(
  parameter int unsigned FRAME_LEN = 16   // bytes per frame, 3..16 (byte_index is 4 bits)
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hsfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // received bytes
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
  // verified frame bytes
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [15:0]                  m_tdata,   // [7:0] frame_byte, [11:8] byte_index
  output logic                         m_tlast    // last_byte
);

  // Register file: one register, word addressed (paddr[1:0] ignored).
  logic [7:0] frame_header;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (32'(paddr[hsfr_pkg::PADDR_W-1:2]) == 32'(hsfr_pkg::REG_HEADER));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_header <= hsfr_pkg::HEADER_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frame_header <= pwdata[7:0];
    end
  end

  assign prdata = reg_sel ? {24'd0, frame_header} : 32'd0;

  // Controller / datapath
  hsfr_pkg::cmd_t    cmd;
  hsfr_pkg::status_t sts;
  logic [7:0]        out_byte;
  logic [3:0]        out_index;

  hsfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsfr_dp #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .header    (frame_header),
    .rx_byte   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .out_index (out_index),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'd0, out_index, out_byte};

`ifndef SYNTHESIS
  // Store writes happen only on an input transfer.
  a_wr_on_transfer: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (s_tvalid && s_tready))
    else $error("store write without input transfer");

  // Never overwrite a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // A stalled result stays put until it is taken.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while stalled");
`endif

endmodule

FILE: tb/header_sum_frame_receiver_test.sv
// Self-checking testbench for header_sum_frame_receiver: byte stream in, verified frames out.
// Depends on hsfr_pkg and the RTL top level; predicts frames internally and checks each transfer.
`timescale 1ns / 1ps

module header_sum_frame_receiver_test;

  localparam int          CLK_PERIOD     = 8;
  localparam int unsigned FRAME_LEN      = 16;
  localparam int unsigned PADDR_W        = hsfr_pkg::PADDR_W;
  localparam int unsigned DRAIN_CYCLES   = 2 * FRAME_LEN + 8;  // replay: store read, then output load, per byte
  localparam int unsigned TIMEOUT_CYCLES = 100000;
  localparam int unsigned REG_SPARE      = hsfr_pkg::REG_HEADER + 1;  // unmapped: dropped
  localparam int unsigned PHASES         = 4;

  // one output transfer as the block should present it
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] byte_index;
    logic       last_byte;
  } frame_out_t;

  // receiver backpressure styles
  typedef enum logic [1:0] {
    RDY_FREE,    // never stalls
    RDY_RANDOM,  // stalls about a third of the time
    RDY_SPARSE   // ready one cycle in seven
  } ready_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;   // [7:0] rx_byte
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [15:0]         m_tdata;        // [7:0] frame_byte, [11:8] byte_index
  logic                m_tlast;        // last_byte

  header_sum_frame_receiver #(
    .FRAME_LEN(FRAME_LEN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame predictor: its own copy of the header register and the capture state.
  // ---------------------------------------------------------------------------
  logic [7:0]  hdr_model = hsfr_pkg::HEADER_RST;
  logic        cap_active = 1'b0;
  logic [4:0]  cap_count = '0;
  logic [7:0]  cap_sum = '0;      // wrapping sum of all bytes but the checksum
  logic [7:0]  cap_store [FRAME_LEN];

  frame_out_t  frame_expect [$];  // transfers still owed by the block
  logic [7:0]  rx_pending [$];    // bytes waiting for the driver
  logic [7:0]  frame_tail [$];    // rest of a frame split across a header write
  int unsigned err_count = 0;

  task automatic absorb_rx_byte(input logic [7:0] rx);
    frame_out_t item;
    if (!cap_active) begin
      // hunting: only a header byte opens a frame
      if (rx != hdr_model) return;
      cap_active = 1'b1;
      cap_count  = '0;
      cap_sum    = '0;
    end
    // inside a frame a header-valued byte is plain data
    cap_store[cap_count] = rx;
    if (cap_count < FRAME_LEN - 1) cap_sum = cap_sum + rx;
    cap_count = cap_count + 1'b1;
    if (cap_count < FRAME_LEN) return;
    cap_active = 1'b0;
    cap_count  = '0;
    // bad checksum: dropped, hunt resumes with the next byte
    if (cap_sum != cap_store[FRAME_LEN-1]) return;
    for (int k = 0; k < FRAME_LEN; k++) begin
      item.frame_byte = cap_store[k];
      item.byte_index = 4'(k);
      item.last_byte  = (k == FRAME_LEN - 1);
      frame_expect.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  // One frame under the current header; bytes from split on are held back.
  task automatic queue_frame(input bit sum_ok, input int unsigned split);
    logic [7:0] body [FRAME_LEN];
    logic [7:0] sum;
    body[0] = hdr_model;
    sum     = hdr_model;
    for (int k = 1; k < FRAME_LEN - 1; k++) begin
      // sprinkle header-valued bytes into the payload
      body[k] = ($urandom_range(0, 7) == 0) ? hdr_model : 8'($urandom_range(0, 255));
      sum     = sum + body[k];
    end
    body[FRAME_LEN-1] = sum_ok ? sum : sum + 8'($urandom_range(1, 255));
    for (int k = 0; k < FRAME_LEN; k++) begin
      if (k < split) rx_pending.push_back(body[k]);
      else frame_tail.push_back(body[k]);
    end
  endtask

  // Line noise that never looks like a header.
  task automatic queue_noise(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == hdr_model) b = ~b;
      rx_pending.push_back(b);
    end
  endtask

  // APB transfer; setup cycle then access cycle, returns prdata of the access.
  task automatic apb_access(input logic [PADDR_W-1:0] addr, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Block idle: all bytes taken, all frames out, then room for a trailing replay.
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_pending.size() != 0 || s_tvalid || frame_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_rx_byte(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= rx_pending.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every output transfer and drives the stall pattern.
  // ---------------------------------------------------------------------------
  ready_mode_t ready_mode  = RDY_FREE;
  int unsigned mode_cycles = 0;
  int unsigned tick        = 0;

  always @(posedge clk) begin
    frame_out_t got;
    frame_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.frame_byte = m_tdata[7:0];
      got.byte_index = m_tdata[11:8];
      got.last_byte  = m_tlast;
      if (frame_expect.size() == 0) begin
        $display("%0t: unexpected transfer byte=%h index=%0d last=%b",
                 $time, got.frame_byte, got.byte_index, got.last_byte);
        err_count++;
      end else begin
        want = frame_expect.pop_front();
        if (got !== want) begin
          $display("%0t: expected byte=%h index=%0d last=%b, got byte=%h index=%0d last=%b",
                   $time, want.frame_byte, want.byte_index, want.last_byte,
                   got.frame_byte, got.byte_index, got.last_byte);
          err_count++;
        end
      end
    end
    if (mode_cycles == 0) begin
      ready_mode  = ready_mode_t'($urandom_range(0, 2));
      mode_cycles = $urandom_range(20, 80);
    end
    mode_cycles--;
    tick++;
    case (ready_mode)
      RDY_FREE: begin
        m_tready <= 1'b1;
      end
      RDY_RANDOM: begin
        m_tready <= ($urandom_range(0, 2) != 0);
      end
      default: begin
        m_tready <= (tick % 7 == 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed frame, then phases under different headers.
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  dir_body [FRAME_LEN-2] = '{8'hDD, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hDD,
                                           8'hFE, 8'h02, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04};
    logic [7:0]  dir_sum;
    logic [7:0]  new_hdr;
    logic [31:0] rd;
    int unsigned start;
    int unsigned pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: noise at both extremes, then a good frame under the reset header
    // whose payload holds header-valued and extreme bytes.
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(hsfr_pkg::HEADER_RST);
    dir_sum = hsfr_pkg::HEADER_RST;
    foreach (dir_body[k]) begin
      rx_pending.push_back(dir_body[k]);
      dir_sum = dir_sum + dir_body[k];
    end
    rx_pending.push_back(dir_sum);

    for (int phase = 0; phase < PHASES; phase++) begin
      // sender holds off until the block has nothing left to deliver
      wait_drained();
      case (phase)
        0:       new_hdr = 8'h00;
        1:       new_hdr = 8'hFF;
        2:       new_hdr = hsfr_pkg::HEADER_RST;
        default: new_hdr = 8'($urandom_range(0, 255));
      endcase
      apb_access(PADDR_W'(4 * hsfr_pkg::REG_HEADER), 1'b1, {24'h0, new_hdr}, rd);
      hdr_model = new_hdr;
      if (phase == 1) begin
        // unmapped register: must leave the header alone
        apb_access(PADDR_W'(4 * REG_SPARE), 1'b1, {24'h0, ~new_hdr}, rd);
      end
      apb_access(PADDR_W'(4 * hsfr_pkg::REG_HEADER), 1'b0, '0, rd);
      if (rd[7:0] !== hdr_model) begin
        $display("%0t: frame_header readback expected %h, got %h", $time, hdr_model, rd[7:0]);
        err_count++;
      end
      @(negedge clk);

      // finish any frame that was open across the header write
      while (frame_tail.size() != 0) rx_pending.push_back(frame_tail.pop_front());

      start = rx_pending.size();
      while (rx_pending.size() - start < 12) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) queue_noise($urandom_range(1, 3));
        else if (pick < 8) queue_frame(1'b1, FRAME_LEN);
        else queue_frame(1'b0, FRAME_LEN);
      end
      // leave a frame open so the next header write lands mid-capture
      if (phase < PHASES - 1 && $urandom_range(0, 2) != 0)
        queue_frame(1'b1, $urandom_range(1, FRAME_LEN - 1));
    end

    wait_drained();
    if (err_count == 0) begin
      $display("[header_sum_frame_receiver] OK");
    end else begin
      $display("[header_sum_frame_receiver] ERROR");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[header_sum_frame_receiver] ERROR");
    $finish;
  end

endmodule
